### design/bsc_pkg.sv
package bsc_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned APB_ADDR_W  = 5;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned REG_IDX_W   = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_DIRECTION   = 3'd0,
        REG_START_CHAR  = 3'd1,
        REG_END_CHAR    = 3'd2,
        REG_ESCAPE_CHAR = 3'd3,
        REG_START_CODE  = 3'd4,
        REG_END_CODE    = 3'd5,
        REG_ESCAPE_CODE = 3'd6
    } reg_idx_t;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [7:0] RST_START_CHAR  = 8'd97;
    localparam logic [7:0] RST_END_CHAR    = 8'd98;
    localparam logic [7:0] RST_ESCAPE_CHAR = 8'd122;
    localparam logic [7:0] RST_START_CODE  = 8'd119;
    localparam logic [7:0] RST_END_CODE    = 8'd120;
    localparam logic [7:0] RST_ESCAPE_CODE = 8'd121;

    typedef struct packed {
        logic       direction;
        logic [7:0] start_char;
        logic [7:0] end_char;
        logic [7:0] escape_char;
        logic [7:0] start_code;
        logic [7:0] end_code;
        logic [7:0] escape_code;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_beat_t;

    typedef struct packed {
        logic       two;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       last;
    } entry_t;

endpackage

### design/bsc_front.sv
module bsc_front
    import bsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     accept,
    input  in_beat_t beat,
    output logic     push,
    output entry_t   entry,
    output logic     pending
);

    logic escape_pending_reg;
    logic escape_pending_next;
    logic emit;

    always_comb
    begin
        emit                = 1'b1;
        escape_pending_next = 1'b0;
        entry.two           = 1'b0;
        entry.first_byte    = cfg.escape_char;
        entry.second_byte   = beat.data_byte;
        entry.last          = beat.last_byte;
        if (cfg.direction == DIR_ENCODE)
        begin
            priority if (beat.data_byte == cfg.escape_char)
            begin
                entry.two         = 1'b1;
                entry.second_byte = cfg.escape_code;
            end
            else if (beat.data_byte == cfg.start_char)
            begin
                entry.two         = 1'b1;
                entry.second_byte = cfg.start_code;
            end
            else if (beat.data_byte == cfg.end_char)
            begin
                entry.two         = 1'b1;
                entry.second_byte = cfg.end_code;
            end
            else
            begin
                entry.two = 1'b0;
            end
        end
        else if (escape_pending_reg)
        begin
            priority if (beat.data_byte == cfg.start_code)
            begin
                entry.second_byte = cfg.start_char;
            end
            else if (beat.data_byte == cfg.end_code)
            begin
                entry.second_byte = cfg.end_char;
            end
            else if (beat.data_byte == cfg.escape_code)
            begin
                entry.second_byte = cfg.escape_char;
            end
            else if (beat.data_byte == cfg.escape_char && !beat.last_byte)
            begin
                // flush the old escape, hold the new one
                entry.second_byte   = cfg.escape_char;
                entry.last          = 1'b0;
                escape_pending_next = 1'b1;
            end
            else
            begin
                entry.two = 1'b1;
            end
        end
        else if (beat.data_byte == cfg.escape_char && !beat.last_byte)
        begin
            emit                = 1'b0;
            escape_pending_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            escape_pending_reg <= escape_pending_next;
        end
    end

    assign push    = accept && emit;
    assign pending = escape_pending_reg;

endmodule

### design/bsc_queue.sv
module bsc_queue
    import bsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  entry_t            push_entry,
    input  logic              pop,
    output entry_t            head,
    output logic              empty,
    output logic              full,
    output logic [QCNT_W-1:0] count
);

    entry_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return p + QPTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign count = count_reg;

endmodule

### design/bsc_back.sv
module bsc_back
    import bsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  entry_t    head,
    input  logic      empty,
    output logic      pop,
    output logic      valid,
    input  logic      stall,
    output out_beat_t data,
    output logic      phase
);

    logic      valid_reg;
    logic      valid_next;
    logic      phase_reg;
    logic      phase_next;
    out_beat_t data_reg;
    out_beat_t data_next;
    logic      load;

    assign load = !valid_reg || !stall;

    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        data_next  = data_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                if (head.two && !phase_reg)
                begin
                    data_next.out_byte = head.first_byte;
                    data_next.out_last = 1'b0;
                    phase_next         = 1'b1;
                end
                else
                begin
                    data_next.out_byte = head.second_byte;
                    data_next.out_last = head.last;
                    phase_next         = 1'b0;
                    pop                = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;
    assign phase = phase_reg;

endmodule

### design/byte_stuffing_codec.sv
// Path: an accepted input beat is written into a queue slot register, then loaded
// into the output data register; a held escape waits for the next beat.
// Throughput: one input beat per cycle while each yields one result beat and the
// sink does not stall; an escape pair holds the output register for both of its
// bytes, and the input stalls once the two-entry queue is full.
// Reset: all configuration registers take their default characters and codes,
// the held escape is cleared, the queue empties and no result beat is valid.
module byte_stuffing_codec
    import bsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  in_beat_t              src_data,
    output logic                  snk_valid,
    input  logic                  snk_stall,
    output out_beat_t             snk_data
);

    cfg_t              cfg_reg;
    logic              cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;
    logic              src_accept;
    logic              push;
    entry_t            push_entry;
    logic              pop;
    entry_t            head;
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
    logic              pending;
    logic              phase;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[REG_IDX_W+1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.direction   <= DIR_ENCODE;
            cfg_reg.start_char  <= RST_START_CHAR;
            cfg_reg.end_char    <= RST_END_CHAR;
            cfg_reg.escape_char <= RST_ESCAPE_CHAR;
            cfg_reg.start_code  <= RST_START_CODE;
            cfg_reg.end_code    <= RST_END_CODE;
            cfg_reg.escape_code <= RST_ESCAPE_CODE;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_DIRECTION:   cfg_reg.direction   <= pwdata[0];
                REG_START_CHAR:  cfg_reg.start_char  <= pwdata[7:0];
                REG_END_CHAR:    cfg_reg.end_char    <= pwdata[7:0];
                REG_ESCAPE_CHAR: cfg_reg.escape_char <= pwdata[7:0];
                REG_START_CODE:  cfg_reg.start_code  <= pwdata[7:0];
                REG_END_CODE:    cfg_reg.end_code    <= pwdata[7:0];
                REG_ESCAPE_CODE: cfg_reg.escape_code <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_DIRECTION:   prdata = APB_DATA_W'(cfg_reg.direction);
            REG_START_CHAR:  prdata = APB_DATA_W'(cfg_reg.start_char);
            REG_END_CHAR:    prdata = APB_DATA_W'(cfg_reg.end_char);
            REG_ESCAPE_CHAR: prdata = APB_DATA_W'(cfg_reg.escape_char);
            REG_START_CODE:  prdata = APB_DATA_W'(cfg_reg.start_code);
            REG_END_CODE:    prdata = APB_DATA_W'(cfg_reg.end_code);
            REG_ESCAPE_CODE: prdata = APB_DATA_W'(cfg_reg.escape_code);
            default:         prdata = '0;
        endcase
    end

    assign src_stall  = full;
    assign src_accept = src_valid && !src_stall;

    bsc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .accept  (src_accept),
        .beat    (src_data),
        .push    (push),
        .entry   (push_entry),
        .pending (pending)
    );

    bsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full),
        .count      (count)
    );

    bsc_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (empty),
        .pop   (pop),
        .valid (snk_valid),
        .stall (snk_stall),
        .data  (snk_data),
        .phase (phase)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue popped while empty");

    a_encode_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        src_accept && (cfg_reg.direction == DIR_ENCODE) |=> !pending)
        else $error("escape held in encode mode");

    a_phase_shown: assert property (@(posedge clk) disable iff (!rst_n)
        phase |-> snk_valid && !snk_data.out_last)
        else $error("pair in progress without first byte shown");

endmodule
